FILE: rtl/rbbp_pkg.sv
// Package for the block buffer pool: sizes, status codes and shared structs.
package rbbp_pkg;

   localparam int SLOTS       = 8;
   localparam int SLOT_W      = $clog2(SLOTS);
   localparam int BLOCK_BYTES = 1024;
   localparam int BLK_SHIFT   = $clog2(BLOCK_BYTES);
   localparam int DEV_W       = 8;
   localparam int BLK_W       = 22;
   localparam int CNT_W       = 8;
   localparam int IDX_W       = 3;
   localparam int STAT_W      = 3;
   localparam int DATA_W      = 32;
   localparam int CSR_AW      = 3;

   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   localparam logic OP_ACQUIRE = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   localparam logic [CSR_AW-1:0] REG_DISK_BASE = 3'd0;
   localparam logic [CSR_AW-1:0] REG_DISK_SIZE = 3'd4;

   typedef enum logic [STAT_W-1:0] {
      ST_OK     = 3'd0,
      ST_RANGE  = 3'd1,
      ST_FULL   = 3'd2,
      ST_UNUSED = 3'd3,
      ST_MAXED  = 3'd4
   } status_type;

   typedef struct packed {
      logic [DATA_W-1:0] disk_base;
      logic [DATA_W-1:0] disk_size;
   } cfg_type;

   typedef struct packed {
      logic              en_count;
      logic              en_tag;
      logic [SLOT_W-1:0] idx;
      logic [CNT_W-1:0]  count;
      logic [DEV_W-1:0]  device;
      logic [BLK_W-1:0]  block;
   } wr_type;

   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic [DEV_W-1:0] device;
      logic [BLK_W-1:0] block;
   } rd_type;

   typedef struct packed {
      logic [IDX_W-1:0]  slot_index;
      logic [DATA_W-1:0] block_address;
      logic              was_hit;
      logic [CNT_W-1:0]  new_count;
      logic [STAT_W-1:0] status;
   } rsp_type;

endpackage

FILE: rtl/rbbp_if.sv
// Valid/ready channel interfaces for request and response beats.
interface rbbp_req_if;
   import rbbp_pkg::*;
   logic             valid;
   logic             ready;
   logic             opcode;
   logic [DEV_W-1:0] device;
   logic [BLK_W-1:0] block_number;
   logic [IDX_W-1:0] release_slot;

   modport source (output valid, opcode, device, block_number, release_slot, input ready);
   modport sink   (input valid, opcode, device, block_number, release_slot, output ready);
endinterface

interface rbbp_rsp_if;
   import rbbp_pkg::*;
   logic              valid;
   logic              ready;
   logic [IDX_W-1:0]  slot_index;
   logic [DATA_W-1:0] block_address;
   logic              was_hit;
   logic [CNT_W-1:0]  new_count;
   logic [STAT_W-1:0] status;

   modport source (output valid, slot_index, block_address, was_hit, new_count, status,
                   input ready);
   modport sink   (input valid, slot_index, block_address, was_hit, new_count, status,
                   output ready);
endinterface

FILE: rtl/rbbp_csr.sv
// APB-style configuration registers: disk image base and size.
module rbbp_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [rbbp_pkg::CSR_AW-1:0]   paddr,
   input  logic [rbbp_pkg::DATA_W-1:0]   pwdata,
   output logic [rbbp_pkg::DATA_W-1:0]   prdata,
   output logic                          pready,
   output rbbp_pkg::cfg_type             cfg
);
   import rbbp_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (paddr)
            REG_DISK_BASE: cfg_in.disk_base = pwdata;
            REG_DISK_SIZE: cfg_in.disk_size = pwdata;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr)
         REG_DISK_BASE: prdata = cfg_ff.disk_base;
         REG_DISK_SIZE: prdata = cfg_ff.disk_size;
         default:       prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/rbbp_slot_store.sv
// Slot table storage: per-slot reference counts and device/block tags.
module rbbp_slot_store (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [rbbp_pkg::SLOT_W-1:0] rd_idx,
   input  rbbp_pkg::wr_type            wr,
   output rbbp_pkg::rd_type            rd
);
   import rbbp_pkg::*;

   logic [CNT_W-1:0] count_ff [SLOTS];
   logic [DEV_W-1:0] device_ff [SLOTS];
   logic [BLK_W-1:0] block_ff [SLOTS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            count_ff[i] <= '0;
         end
      end else if (wr.en_count) begin
         count_ff[wr.idx] <= wr.count;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en_tag) begin
         device_ff[wr.idx] <= wr.device;
         block_ff[wr.idx]  <= wr.block;
      end
   end

   assign rd.count  = count_ff[rd_idx];
   assign rd.device = device_ff[rd_idx];
   assign rd.block  = block_ff[rd_idx];

endmodule

FILE: rtl/rbbp_ctrl.sv
// Sequencer: range check, one-slot-per-cycle tag compare scan, count update.
module rbbp_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  rbbp_pkg::cfg_type           cfg,
   rbbp_req_if.sink                    req,
   rbbp_rsp_if.source                  rsp,
   output logic [rbbp_pkg::SLOT_W-1:0] rd_idx,
   input  rbbp_pkg::rd_type            rd,
   output rbbp_pkg::wr_type            wr
);
   import rbbp_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_SCAN,
      S_FINISH,
      S_DONE
   } state_type;

   state_type          st_ff, st_in;
   logic               op_ff, op_in;
   logic [DEV_W-1:0]   dev_ff, dev_in;
   logic [BLK_W-1:0]   blk_ff, blk_in;
   logic [IDX_W-1:0]   rel_ff, rel_in;
   logic [SLOT_W-1:0]  ptr_ff, ptr_in;
   logic [SLOT_W-1:0]  free_ff, free_in;
   logic               found_ff, found_in;
   logic [DATA_W-1:0]  addr_ff, addr_in;
   rsp_type            res_ff, res_in;
   rsp_type            out_ff, out_in;
   logic               out_valid_ff, out_valid_in;

   logic [BLK_W+BLK_SHIFT:0] end_byte;
   logic                     range_bad;
   logic                     match;
   logic                     accept;

   assign accept    = req.valid && req.ready;
   assign end_byte  = {({1'b0, blk_ff} + (BLK_W+1)'(1)), BLK_SHIFT'(0)};
   assign range_bad = (cfg.disk_base == '0) ||
                      (end_byte > (BLK_W+BLK_SHIFT+1)'(cfg.disk_size));
   assign match     = (rd.count != '0) && (rd.block == blk_ff) && (rd.device == dev_ff);

   always_comb begin
      st_in        = st_ff;
      op_in        = op_ff;
      dev_in       = dev_ff;
      blk_in       = blk_ff;
      rel_in       = rel_ff;
      ptr_in       = ptr_ff;
      free_in      = free_ff;
      found_in     = found_ff;
      addr_in      = addr_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      wr           = '0;
      wr.idx       = ptr_ff;
      wr.device    = dev_ff;
      wr.block     = blk_ff;

      case (st_ff)
         S_IDLE: begin
            if (accept) begin
               op_in  = req.opcode;
               dev_in = req.device;
               blk_in = req.block_number;
               rel_in = req.release_slot;
               ptr_in = (req.opcode == OP_RELEASE) ? SLOT_W'(req.release_slot) : '0;
               st_in  = S_CHECK;
            end
         end
         S_CHECK: begin
            res_in = '0;
            st_in  = S_DONE;
            if (op_ff == OP_RELEASE) begin
               res_in.slot_index = rel_ff;
               if ((32'(rel_ff) >= SLOTS) || (rd.count == '0)) begin
                  res_in.status = ST_UNUSED;
               end else begin
                  wr.en_count      = 1'b1;
                  wr.count         = rd.count - CNT_W'(1);
                  res_in.new_count = rd.count - CNT_W'(1);
                  res_in.status    = ST_OK;
               end
            end else if (range_bad) begin
               res_in.status = ST_RANGE;
            end else begin
               addr_in  = cfg.disk_base + DATA_W'({blk_ff, BLK_SHIFT'(0)});
               found_in = 1'b0;
               ptr_in   = '0;
               st_in    = S_SCAN;
            end
         end
         S_SCAN: begin
            if (match) begin
               res_in.slot_index    = IDX_W'(ptr_ff);
               res_in.block_address = addr_ff;
               res_in.was_hit       = 1'b1;
               if (rd.count == CNT_MAX) begin
                  res_in.new_count = CNT_MAX;
                  res_in.status    = ST_MAXED;
               end else begin
                  wr.en_count      = 1'b1;
                  wr.count         = rd.count + CNT_W'(1);
                  res_in.new_count = rd.count + CNT_W'(1);
                  res_in.status    = ST_OK;
               end
               st_in = S_DONE;
            end else begin
               if ((rd.count == '0) && !found_ff) begin
                  free_in  = ptr_ff;
                  found_in = 1'b1;
               end
               if (ptr_ff == SLOT_W'(SLOTS-1)) begin
                  st_in = S_FINISH;
               end else begin
                  ptr_in = ptr_ff + SLOT_W'(1);
               end
            end
         end
         S_FINISH: begin
            res_in = '0;
            if (!found_ff) begin
               res_in.status = ST_FULL;
            end else begin
               wr.en_count          = 1'b1;
               wr.en_tag            = 1'b1;
               wr.idx               = free_ff;
               wr.count             = CNT_W'(1);
               res_in.slot_index    = IDX_W'(free_ff);
               res_in.block_address = addr_ff;
               res_in.new_count     = CNT_W'(1);
               res_in.status        = ST_OK;
            end
            st_in = S_DONE;
         end
         S_DONE: begin
            if (!out_valid_ff || rsp.ready) begin
               out_in       = res_ff;
               out_valid_in = 1'b1;
               st_in        = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= S_IDLE;
         out_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         ptr_ff       <= '0;
      end else begin
         st_ff        <= st_in;
         out_valid_ff <= out_valid_in;
         found_ff     <= found_in;
         ptr_ff       <= ptr_in;
      end
      op_ff   <= op_in;
      dev_ff  <= dev_in;
      blk_ff  <= blk_in;
      rel_ff  <= rel_in;
      free_ff <= free_in;
      addr_ff <= addr_in;
      res_ff  <= res_in;
      out_ff  <= out_in;
   end

   assign rd_idx            = ptr_ff;
   assign req.ready         = (st_ff == S_IDLE);
   assign rsp.valid         = out_valid_ff;
   assign rsp.slot_index    = out_ff.slot_index;
   assign rsp.block_address = out_ff.block_address;
   assign rsp.was_hit       = out_ff.was_hit;
   assign rsp.new_count     = out_ff.new_count;
   assign rsp.status        = out_ff.status;

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_IDLE || st_ff == S_DONE) |-> !wr.en_count && !wr.en_tag)
      else $error("slot table written outside an active step");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req.ready)
      else $error("request accepted while a step is in flight");

   a_hit_status: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.was_hit) |->
         (rsp.status == ST_OK || rsp.status == ST_MAXED))
      else $error("hit reported with an error status");

   a_err_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && (rsp.status == ST_RANGE || rsp.status == ST_FULL)) |->
         (rsp.slot_index == '0 && rsp.new_count == '0 && rsp.block_address == '0))
      else $error("acquire error beat carries nonzero fields");

endmodule

FILE: rtl/refcounted_block_buffer_pool_top.sv
// Acquire: on a miss or a full table the request passes through check, a scan of every slot, claim
// and output; a hit ends the scan at the matching slot, and a range error ends at the check.
// Release: a check step, then the result beat is registered.
// One request in flight; the next request beat is taken once the result is loaded, and it is
// taken while the last result beat waits.
// Synchronous active-high reset clears all reference counts, disk_base and disk_size.
module refcounted_block_buffer_pool_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [rbbp_pkg::CSR_AW-1:0] paddr,
   input  logic [rbbp_pkg::DATA_W-1:0] pwdata,
   output logic [rbbp_pkg::DATA_W-1:0] prdata,
   output logic                        pready,
   rbbp_req_if.sink                    req,
   rbbp_rsp_if.source                  rsp
);
   import rbbp_pkg::*;

   cfg_type           cfg;
   wr_type            wr;
   rd_type            rd;
   logic [SLOT_W-1:0] rd_idx;

   rbbp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   rbbp_slot_store u_store (
      .clock  (clock),
      .reset  (reset),
      .rd_idx (rd_idx),
      .wr     (wr),
      .rd     (rd)
   );

   rbbp_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .req    (req),
      .rsp    (rsp),
      .rd_idx (rd_idx),
      .rd     (rd),
      .wr     (wr)
   );

endmodule
